@@ src/drc_pkg.sv @@
// Shared types, constants and helper functions for the derivative ranking compare unit.
// No dependencies; imported by every module of the block.
package drc_pkg;

  localparam int NUM_DERIVATIONS = 4;
  localparam int ORDER_BITS      = 8;
  localparam int NUM_SUBSCRIPTS  = 4;
  localparam int SUBSCRIPT_BITS  = 8;

  localparam int POS_BITS    = 8;
  localparam int GROUP_BITS  = 4;
  localparam int KIND_BITS   = 2;
  localparam int COUNT_BITS  = 3;
  localparam int MODE_BITS   = 3;
  localparam int IN_TUSER_W  = 1 + 2 * KIND_BITS;
  localparam int OUT_TDATA_W = 8;

  localparam logic [GROUP_BITS-1:0] NO_GROUP = 4'hF;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_GRLEX_A     = 3'd0,
    MODE_GRLEX_B     = 3'd1,
    MODE_DEGREVLEX_A = 3'd2,
    MODE_DEGREVLEX_B = 3'd3,
    MODE_LEX         = 3'd4
  } mode_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_OPERATOR  = 2'd0,
    KIND_DEPENDENT = 2'd1,
    KIND_OTHER     = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DEC_NONE = 2'd0,
    DEC_LESS = 2'd1,
    DEC_NOT  = 2'd2,
    DEC_ERR  = 2'd3
  } dec_t;

  typedef struct packed {
    logic is_less;
    logic error_flag;
  } drc_result_t;

  function automatic int field_bits(int nd, int ob, int ns, int sb);
    return 2 * nd * ob + 2 * POS_BITS + 2 * GROUP_BITS + 2 * ns * sb + ns + COUNT_BITS;
  endfunction

  function automatic int in_tdata_w(int nd, int ob, int ns, int sb);
    return ((field_bits(nd, ob, ns, sb) + 7) / 8) * 8;
  endfunction

endpackage

@@ src/drc_decide.sv @@
// Combinational ranking decision for one registered transaction.
// Depends on drc_pkg for the mode, kind and decision codes.
module drc_decide #(
  parameter int NUM_DERIVATIONS = drc_pkg::NUM_DERIVATIONS,
  parameter int ORDER_BITS      = drc_pkg::ORDER_BITS,
  parameter int NUM_SUBSCRIPTS  = drc_pkg::NUM_SUBSCRIPTS,
  parameter int SUBSCRIPT_BITS  = drc_pkg::SUBSCRIPT_BITS,
  parameter int IN_TDATA_W      = drc_pkg::in_tdata_w(NUM_DERIVATIONS, ORDER_BITS,
                                                      NUM_SUBSCRIPTS, SUBSCRIPT_BITS)
) (
  input  logic [drc_pkg::MODE_BITS-1:0]  mode,
  input  logic [IN_TDATA_W-1:0]          tdata,
  input  logic [drc_pkg::IN_TUSER_W-1:0] tuser,
  output drc_pkg::drc_result_t           result
);
  import drc_pkg::*;

  localparam int OW       = NUM_DERIVATIONS * ORDER_BITS;
  localparam int SW       = NUM_SUBSCRIPTS * SUBSCRIPT_BITS;
  localparam int V_ORD_LO = 0;
  localparam int W_ORD_LO = OW;
  localparam int V_BLK_LO = 2 * OW;
  localparam int W_BLK_LO = V_BLK_LO + POS_BITS;
  localparam int V_GRP_LO = W_BLK_LO + POS_BITS;
  localparam int W_GRP_LO = V_GRP_LO + GROUP_BITS;
  localparam int V_SUB_LO = W_GRP_LO + GROUP_BITS;
  localparam int W_SUB_LO = V_SUB_LO + SW;
  localparam int MASK_LO  = W_SUB_LO + SW;
  localparam int CNT_LO   = MASK_LO + NUM_SUBSCRIPTS;
  localparam int TOT_W    = ORDER_BITS + $clog2(NUM_DERIVATIONS);
  localparam int SSUM_W   = SUBSCRIPT_BITS + $clog2(NUM_SUBSCRIPTS) + 1;

  logic [ORDER_BITS-1:0]            vo [NUM_DERIVATIONS];
  logic [ORDER_BITS-1:0]            wo [NUM_DERIVATIONS];
  logic signed [SUBSCRIPT_BITS-1:0] vs [NUM_SUBSCRIPTS];
  logic signed [SUBSCRIPT_BITS-1:0] ws [NUM_SUBSCRIPTS];
  logic [TOT_W-1:0]                 tot_v, tot_w;
  logic signed [SSUM_W-1:0]         sum_v, sum_w;
  logic [NUM_SUBSCRIPTS-1:0]        dir_mask;
  logic [COUNT_BITS-1:0]            sub_cnt;
  logic [POS_BITS-1:0]              blk_v, blk_w;
  logic [GROUP_BITS-1:0]            grp_v, grp_w;
  logic                             same_sym;
  logic [KIND_BITS-1:0]             kind_v, kind_w;
  logic                             orders_first, reverse, mode_ok;
  dec_t                             ord_dec, lex_dec, idx_dec, sym_dec, tot_dec, dec;

  assign blk_v    = tdata[V_BLK_LO +: POS_BITS];
  assign blk_w    = tdata[W_BLK_LO +: POS_BITS];
  assign grp_v    = tdata[V_GRP_LO +: GROUP_BITS];
  assign grp_w    = tdata[W_GRP_LO +: GROUP_BITS];
  assign dir_mask = tdata[MASK_LO +: NUM_SUBSCRIPTS];
  assign sub_cnt  = tdata[CNT_LO +: COUNT_BITS];
  assign same_sym = tuser[0];
  assign kind_v   = tuser[1 +: KIND_BITS];
  assign kind_w   = tuser[1 + KIND_BITS +: KIND_BITS];

  assign mode_ok      = (mode <= MODE_LEX);
  assign orders_first = (mode == MODE_GRLEX_B) || (mode == MODE_DEGREVLEX_B) ||
                        (mode == MODE_LEX);
  assign reverse      = (mode == MODE_DEGREVLEX_A) || (mode == MODE_DEGREVLEX_B);

  always_comb begin
    tot_v = '0;
    tot_w = '0;
    for (int k = 0; k < NUM_DERIVATIONS; k++) begin
      vo[k] = tdata[V_ORD_LO + k * ORDER_BITS +: ORDER_BITS];
      wo[k] = tdata[W_ORD_LO + k * ORDER_BITS +: ORDER_BITS];
      tot_v = tot_v + TOT_W'(vo[k]);
      tot_w = tot_w + TOT_W'(wo[k]);
    end
    if (tot_v != tot_w) begin
      tot_dec = (tot_v < tot_w) ? DEC_LESS : DEC_NOT;
    end else begin
      tot_dec = DEC_NONE;
    end
    ord_dec = DEC_NONE;
    if (reverse) begin
      for (int k = 0; k < NUM_DERIVATIONS; k++) begin
        if (vo[k] != wo[k]) ord_dec = (vo[k] > wo[k]) ? DEC_LESS : DEC_NOT;
      end
    end else begin
      for (int k = NUM_DERIVATIONS - 1; k >= 0; k--) begin
        if (vo[k] != wo[k]) ord_dec = (vo[k] < wo[k]) ? DEC_LESS : DEC_NOT;
      end
    end
  end

  always_comb begin
    sum_v   = '0;
    sum_w   = '0;
    lex_dec = DEC_NONE;
    for (int i = 0; i < NUM_SUBSCRIPTS; i++) begin
      vs[i] = tdata[V_SUB_LO + i * SUBSCRIPT_BITS +: SUBSCRIPT_BITS];
      ws[i] = tdata[W_SUB_LO + i * SUBSCRIPT_BITS +: SUBSCRIPT_BITS];
      if (i < int'(sub_cnt)) begin
        if (dir_mask[i]) begin
          sum_v = sum_v + SSUM_W'(vs[i]);
          sum_w = sum_w + SSUM_W'(ws[i]);
        end else begin
          sum_v = sum_v - SSUM_W'(vs[i]);
          sum_w = sum_w - SSUM_W'(ws[i]);
        end
      end
    end
    for (int i = NUM_SUBSCRIPTS - 1; i >= 0; i--) begin
      if ((i < int'(sub_cnt)) && (vs[i] != ws[i])) begin
        if (dir_mask[i]) begin
          lex_dec = (vs[i] < ws[i]) ? DEC_LESS : DEC_NOT;
        end else begin
          lex_dec = (vs[i] > ws[i]) ? DEC_LESS : DEC_NOT;
        end
      end
    end
  end

  always_comb begin
    if ((grp_v == NO_GROUP) != (grp_w == NO_GROUP)) begin
      idx_dec = DEC_ERR;
    end else if ((sub_cnt == '0) || (int'(sub_cnt) > NUM_SUBSCRIPTS)) begin
      idx_dec = DEC_ERR;
    end else if (sum_v != sum_w) begin
      idx_dec = (sum_v < sum_w) ? DEC_LESS : DEC_NOT;
    end else if (lex_dec != DEC_NONE) begin
      idx_dec = lex_dec;
    end else if (grp_v == grp_w) begin
      idx_dec = DEC_ERR;
    end else begin
      idx_dec = (grp_v > grp_w) ? DEC_LESS : DEC_NOT;
    end

    if (kind_v == KIND_OPERATOR) begin
      sym_dec = same_sym ? DEC_NONE : DEC_ERR;
    end else if (same_sym) begin
      sym_dec = DEC_NONE;
    end else if ((kind_v != KIND_DEPENDENT) || (kind_w != KIND_DEPENDENT)) begin
      sym_dec = DEC_ERR;
    end else if (blk_v != blk_w) begin
      sym_dec = (blk_v > blk_w) ? DEC_LESS : DEC_NOT;
    end else begin
      sym_dec = idx_dec;
    end
  end

  always_comb begin
    if (!mode_ok) begin
      dec = DEC_ERR;
    end else if ((mode != MODE_LEX) && (tot_dec != DEC_NONE)) begin
      dec = tot_dec;
    end else if (orders_first) begin
      dec = (ord_dec != DEC_NONE) ? ord_dec : sym_dec;
    end else begin
      dec = (sym_dec != DEC_NONE) ? sym_dec : ord_dec;
    end
    result.is_less    = (dec == DEC_LESS);
    result.error_flag = (dec == DEC_ERR) || (dec == DEC_NONE);
  end

endmodule

@@ src/derivative_ranking_compare_unit.sv @@
// Top level of the derivative ranking compare unit: stream ports, mode register, pipeline.
// Depends on drc_pkg and drc_decide.
//
// Usage:
//   Each input transaction carries one pair of derivatives v and w; the block
//   answers with one result transaction saying whether v ranks strictly below
//   w under the subranking held in the mode register, and flags inconsistent
//   or identical pairs on out_tuser (is_less is then 0).
//   The mode register is loaded through cfg_wr_en / cfg_wr_data and must only
//   change while no transaction is in flight.
//   The path from input acceptance to result is the input register, the decision
//   logic and the result register; out_tvalid rises once the transaction moves
//   into the result register, which waits while a stalled result is held there.
//   Throughput is one transaction per cycle while out_tready stays high; the input
//   register and the result register each hold one transaction, so two may be in flight.
//   When the receiver drops out_tready the result register holds and the input
//   register fills; in_tready falls only once both are occupied.
//   Reset clears both valid flags and sets the mode to grlexA.
module derivative_ranking_compare_unit #(
  parameter int NUM_DERIVATIONS = drc_pkg::NUM_DERIVATIONS,
  parameter int ORDER_BITS      = drc_pkg::ORDER_BITS,
  parameter int NUM_SUBSCRIPTS  = drc_pkg::NUM_SUBSCRIPTS,
  parameter int SUBSCRIPT_BITS  = drc_pkg::SUBSCRIPT_BITS,
  parameter int IN_TDATA_W      = drc_pkg::in_tdata_w(NUM_DERIVATIONS, ORDER_BITS,
                                                      NUM_SUBSCRIPTS, SUBSCRIPT_BITS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [drc_pkg::MODE_BITS-1:0]   cfg_wr_data,   // ranking_mode
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // v_orders, w_orders, v_block_pos, w_block_pos, v_group_pos, w_group_pos,
  // v_subscripts, w_subscripts, group_shape, zero pad
  input  logic [IN_TDATA_W-1:0]           in_tdata,
  input  logic [drc_pkg::IN_TUSER_W-1:0]  in_tuser,      // same_symbol, v_kind, w_kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [drc_pkg::OUT_TDATA_W-1:0] out_tdata,     // is_less, zero pad
  output logic                            out_tuser      // error_flag
);
  import drc_pkg::*;

  logic [MODE_BITS-1:0]  ranking_mode_r;
  logic                  s1_valid_r;
  logic [IN_TDATA_W-1:0] s1_tdata_r;
  logic [IN_TUSER_W-1:0] s1_tuser_r;
  logic                  out_valid_r;
  drc_result_t           out_res_r;
  drc_result_t           res_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ranking_mode_r <= MODE_GRLEX_A;
    end else if (cfg_wr_en) begin
      ranking_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_tdata_r <= in_tdata;
      s1_tuser_r <= in_tuser;
    end
  end

  drc_decide #(
    .NUM_DERIVATIONS (NUM_DERIVATIONS),
    .ORDER_BITS      (ORDER_BITS),
    .NUM_SUBSCRIPTS  (NUM_SUBSCRIPTS),
    .SUBSCRIPT_BITS  (SUBSCRIPT_BITS),
    .IN_TDATA_W      (IN_TDATA_W)
  ) u_decide (
    .mode   (ranking_mode_r),
    .tdata  (s1_tdata_r),
    .tuser  (s1_tuser_r),
    .result (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_res_r.is_less};
  assign out_tuser  = out_res_r.error_flag;

endmodule

@@ src/drc_checker.sv @@
// Port-level checks for the derivative ranking compare unit, bound to the top level.
// Depends on drc_pkg and derivative_ranking_compare_unit.
module drc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [drc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import drc_pkg::*;

  a_err_not_less: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tuser))
    else $error("result marked both less and error");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_two_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted transaction did not reach the output in two cycles");

endmodule

bind derivative_ranking_compare_unit drc_checker u_drc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ sim/derivative_ranking_checker.sv @@
// Checker for the derivative ranking compare unit: predicts each decision and scores results.
// Depends on drc_pkg; instantiated by the testbench top beside the block.
`timescale 1ns / 1ps
module derivative_ranking_checker #(
  parameter int PAIR_W = drc_pkg::in_tdata_w(drc_pkg::NUM_DERIVATIONS, drc_pkg::ORDER_BITS,
                                             drc_pkg::NUM_SUBSCRIPTS,
                                             drc_pkg::SUBSCRIPT_BITS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [drc_pkg::MODE_BITS-1:0]   cfg_wr_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [PAIR_W-1:0]               in_tdata,
  input  logic [drc_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [drc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  output int                              fail_count,
  output int                              pending_count
);
  import drc_pkg::*;

  localparam int ORD_W = NUM_DERIVATIONS * ORDER_BITS;
  localparam int SUB_W = NUM_SUBSCRIPTS * SUBSCRIPT_BITS;
  localparam int PAD_W = PAIR_W - field_bits(NUM_DERIVATIONS, ORDER_BITS, NUM_SUBSCRIPTS,
                                             SUBSCRIPT_BITS);

  typedef struct packed {
    logic [PAD_W-1:0]                     pad;
    logic [COUNT_BITS+NUM_SUBSCRIPTS-1:0] group_shape;
    logic [SUB_W-1:0]                     w_subs;
    logic [SUB_W-1:0]                     v_subs;
    logic [GROUP_BITS-1:0]                w_group;
    logic [GROUP_BITS-1:0]                v_group;
    logic [POS_BITS-1:0]                  w_block;
    logic [POS_BITS-1:0]                  v_block;
    logic [ORD_W-1:0]                     w_orders;
    logic [ORD_W-1:0]                     v_orders;
  } derivative_pair_t;

  logic [MODE_BITS-1:0] ranking_mode_q = MODE_GRLEX_A;
  drc_result_t          decision_q[$];
  int                   failures = 0;

  assign fail_count = failures;

  function automatic int order_total(logic [ORD_W-1:0] o);
    int sum;
    sum = 0;
    for (int i = 0; i < NUM_DERIVATIONS; i++) sum += int'(o[i*ORDER_BITS +: ORDER_BITS]);
    return sum;
  endfunction

  function automatic dec_t order_compare(logic [ORD_W-1:0] vo, logic [ORD_W-1:0] wo,
                                         bit descending);
    int idx;
    int a;
    int b;
    for (int k = 0; k < NUM_DERIVATIONS; k++) begin
      idx = descending ? NUM_DERIVATIONS - 1 - k : k;
      a = int'(vo[idx*ORDER_BITS +: ORDER_BITS]);
      b = int'(wo[idx*ORDER_BITS +: ORDER_BITS]);
      if (a != b) begin
        if (descending) return (a > b) ? DEC_LESS : DEC_NOT;
        return (a < b) ? DEC_LESS : DEC_NOT;
      end
    end
    return DEC_NONE;
  endfunction

  function automatic int subscript_at(logic [SUB_W-1:0] s, int i);
    logic signed [SUBSCRIPT_BITS-1:0] raw;
    raw = s[i*SUBSCRIPT_BITS +: SUBSCRIPT_BITS];
    return int'(raw);
  endfunction

  function automatic dec_t subscript_compare(derivative_pair_t p);
    logic [NUM_SUBSCRIPTS-1:0] ascending;
    int count;
    int vsum;
    int wsum;
    int a;
    int b;
    ascending = p.group_shape[NUM_SUBSCRIPTS-1:0];
    count = int'(p.group_shape[NUM_SUBSCRIPTS +: COUNT_BITS]);
    vsum = 0;
    wsum = 0;
    if ((p.v_group == NO_GROUP) != (p.w_group == NO_GROUP)) return DEC_ERR;
    if (count == 0 || count > NUM_SUBSCRIPTS) return DEC_ERR;
    for (int i = 0; i < count; i++) begin
      a = subscript_at(p.v_subs, i);
      b = subscript_at(p.w_subs, i);
      if (ascending[i]) begin
        vsum += a;
        wsum += b;
      end else begin
        vsum -= a;
        wsum -= b;
      end
    end
    if (vsum != wsum) return (vsum < wsum) ? DEC_LESS : DEC_NOT;
    for (int i = 0; i < count; i++) begin
      a = subscript_at(p.v_subs, i);
      b = subscript_at(p.w_subs, i);
      if (a != b) begin
        if (ascending[i]) return (a < b) ? DEC_LESS : DEC_NOT;
        return (a > b) ? DEC_LESS : DEC_NOT;
      end
    end
    if (p.v_group == p.w_group) return DEC_ERR;
    return (p.v_group > p.w_group) ? DEC_LESS : DEC_NOT;
  endfunction

  function automatic dec_t symbol_compare(derivative_pair_t p, logic same,
                                          logic [KIND_BITS-1:0] vk, logic [KIND_BITS-1:0] wk);
    if (vk == KIND_OPERATOR) return same ? DEC_NONE : DEC_ERR;
    if (same) return DEC_NONE;
    if (vk != KIND_DEPENDENT || wk != KIND_DEPENDENT) return DEC_ERR;
    if (p.v_block != p.w_block) return (p.v_block > p.w_block) ? DEC_LESS : DEC_NOT;
    return subscript_compare(p);
  endfunction

  function automatic dec_t rank_pair(derivative_pair_t p, logic [IN_TUSER_W-1:0] flags,
                                     logic [MODE_BITS-1:0] mode);
    bit   orders_first;
    bit   descending;
    int   tv;
    int   tw;
    dec_t d;
    if (mode > MODE_LEX) return DEC_ERR;
    orders_first = (mode == MODE_GRLEX_B || mode == MODE_DEGREVLEX_B || mode == MODE_LEX);
    descending = (mode == MODE_DEGREVLEX_A || mode == MODE_DEGREVLEX_B);
    d = DEC_NONE;
    if (mode != MODE_LEX) begin
      tv = order_total(p.v_orders);
      tw = order_total(p.w_orders);
      if (tv != tw) d = (tv < tw) ? DEC_LESS : DEC_NOT;
    end
    if (d == DEC_NONE) begin
      if (orders_first) begin
        d = order_compare(p.v_orders, p.w_orders, descending);
        if (d == DEC_NONE)
          d = symbol_compare(p, flags[0], flags[KIND_BITS:1], flags[2*KIND_BITS:KIND_BITS+1]);
      end else begin
        d = symbol_compare(p, flags[0], flags[KIND_BITS:1], flags[2*KIND_BITS:KIND_BITS+1]);
        if (d == DEC_NONE) d = order_compare(p.v_orders, p.w_orders, descending);
      end
    end
    if (d == DEC_NONE) d = DEC_ERR;
    return d;
  endfunction

  always @(posedge clk) begin : score
    drc_result_t want;
    dec_t        d;
    if (!rst_n) begin
      ranking_mode_q = MODE_GRLEX_A;
      decision_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (decision_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected (is_less %0b error %0b)",
                   $time, out_tdata[0], out_tuser);
          failures++;
        end else begin
          want = decision_q.pop_front();
          if (out_tdata[0] !== want.is_less) begin
            $display("%0t: is_less expected %0b actual %0b", $time, want.is_less, out_tdata[0]);
            failures++;
          end
          if (out_tuser !== want.error_flag) begin
            $display("%0t: error_flag expected %0b actual %0b", $time, want.error_flag,
                     out_tuser);
            failures++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        d = rank_pair(derivative_pair_t'(in_tdata), in_tuser, ranking_mode_q);
        want.is_less = (d == DEC_LESS);
        want.error_flag = (d == DEC_ERR);
        decision_q.push_back(want);
      end
      if (cfg_wr_en) ranking_mode_q = cfg_wr_data;
    end
    pending_count <= decision_q.size();
  end

endmodule

@@ sim/testbench.sv @@
// Testbench top for the derivative ranking compare unit: clock, reset, stimulus and verdict.
// Depends on drc_pkg, derivative_ranking_compare_unit and derivative_ranking_checker.
`timescale 1ns / 1ps
module testbench;
  import drc_pkg::*;

  localparam int PAIR_W = in_tdata_w(NUM_DERIVATIONS, ORDER_BITS, NUM_SUBSCRIPTS,
                                     SUBSCRIPT_BITS);
  localparam int ORD_W  = NUM_DERIVATIONS * ORDER_BITS;
  localparam int SUB_W  = NUM_SUBSCRIPTS * SUBSCRIPT_BITS;
  localparam int SHAPE_W = COUNT_BITS + NUM_SUBSCRIPTS;
  localparam logic [MODE_BITS-1:0] MODE_UNDEF_LO = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_UNDEF_HI = 3'd7;
  localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_ITEMS = 280;
  localparam int UNDEF_ITEMS = 30;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [MODE_BITS-1:0]   cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [PAIR_W-1:0]      in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  int                     fail_count;
  int                     pending_count;

  int sender_idle = 0;
  int receiver_idle = 0;

  logic [ORD_W-1:0]      p_vo, p_wo;
  logic                  p_same;
  logic [KIND_BITS-1:0]  p_vk, p_wk;
  logic [POS_BITS-1:0]   p_vb, p_wb;
  logic [GROUP_BITS-1:0] p_vg, p_wg;
  logic [SUB_W-1:0]      p_vs, p_ws;
  logic [SHAPE_W-1:0]    p_shape;

  derivative_ranking_compare_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  derivative_ranking_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= receiver_idle);
  end

  task automatic push_pair();
    int gap;
    if ($urandom_range(99) < sender_idle) begin
      gap = $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= PAIR_W'({p_shape, p_ws, p_vs, p_wg, p_vg, p_wb, p_vb, p_wo, p_vo});
    in_tuser <= {p_wk, p_vk, p_same};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
  endtask

  task automatic load_mode(input logic [MODE_BITS-1:0] m);
    drain();
    repeat (3) @(negedge clk);
    cfg_wr_data <= m;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic directed(input logic [ORD_W-1:0] vo, input logic [ORD_W-1:0] wo,
                          input logic same, input logic [KIND_BITS-1:0] vk,
                          input logic [KIND_BITS-1:0] wk, input logic [POS_BITS-1:0] vb,
                          input logic [POS_BITS-1:0] wb, input logic [GROUP_BITS-1:0] vg,
                          input logic [GROUP_BITS-1:0] wg, input logic [SUB_W-1:0] vs,
                          input logic [SUB_W-1:0] ws, input logic [SHAPE_W-1:0] shape);
    p_vo = vo; p_wo = wo; p_same = same; p_vk = vk; p_wk = wk; p_vb = vb; p_wb = wb;
    p_vg = vg; p_wg = wg; p_vs = vs; p_ws = ws; p_shape = shape;
    push_pair();
  endtask

  task automatic make_random_pair();
    int pick;
    int i;
    int j;
    logic [ORDER_BITS-1:0] t;
    pick = $urandom_range(9);
    p_vo = $urandom();
    if (pick < 2) begin
      p_wo = $urandom();
    end else if (pick < 5) begin
      for (i = 0; i < NUM_DERIVATIONS; i++) begin
        p_vo[i*ORDER_BITS +: ORDER_BITS] = ORDER_BITS'($urandom_range(3));
        p_wo[i*ORDER_BITS +: ORDER_BITS] = ORDER_BITS'($urandom_range(3));
      end
    end else begin
      p_wo = p_vo;
      if (pick < 8) begin
        i = $urandom_range(NUM_DERIVATIONS - 1);
        j = $urandom_range(NUM_DERIVATIONS - 1);
        t = p_wo[i*ORDER_BITS +: ORDER_BITS];
        p_wo[i*ORDER_BITS +: ORDER_BITS] = p_wo[j*ORDER_BITS +: ORDER_BITS];
        p_wo[j*ORDER_BITS +: ORDER_BITS] = t;
      end
    end

    pick = $urandom_range(9);
    p_vs = $urandom();
    if (pick < 3) begin
      p_ws = $urandom();
    end else if (pick < 6) begin
      for (i = 0; i < NUM_SUBSCRIPTS; i++) begin
        p_vs[i*SUBSCRIPT_BITS +: SUBSCRIPT_BITS] = SUBSCRIPT_BITS'(int'($urandom_range(2)) - 1);
        p_ws[i*SUBSCRIPT_BITS +: SUBSCRIPT_BITS] = SUBSCRIPT_BITS'(int'($urandom_range(2)) - 1);
      end
    end else begin
      p_ws = p_vs;
      if (pick < 8) begin
        i = $urandom_range(NUM_SUBSCRIPTS - 1);
        p_ws[i*SUBSCRIPT_BITS +: SUBSCRIPT_BITS] =
          p_ws[i*SUBSCRIPT_BITS +: SUBSCRIPT_BITS] + SUBSCRIPT_BITS'(int'($urandom_range(2)) - 1);
      end
    end

    p_vb = POS_BITS'($urandom());
    p_wb = ($urandom_range(9) < 6) ? p_vb : POS_BITS'($urandom());

    pick = $urandom_range(9);
    if (pick < 4) begin
      p_vg = NO_GROUP;
      p_wg = NO_GROUP;
    end else if (pick < 8) begin
      p_vg = GROUP_BITS'($urandom_range(2));
      p_wg = GROUP_BITS'($urandom_range(2));
    end else if (pick < 9) begin
      p_vg = GROUP_BITS'($urandom_range(14));
      p_wg = NO_GROUP;
      if ($urandom_range(1)) begin
        p_wg = p_vg;
        p_vg = NO_GROUP;
      end
    end else begin
      p_vg = GROUP_BITS'($urandom());
      p_wg = GROUP_BITS'($urandom());
    end

    p_shape[NUM_SUBSCRIPTS-1:0] = NUM_SUBSCRIPTS'($urandom());
    if ($urandom_range(99) < 85)
      p_shape[NUM_SUBSCRIPTS +: COUNT_BITS] = COUNT_BITS'($urandom_range(NUM_SUBSCRIPTS, 1));
    else
      p_shape[NUM_SUBSCRIPTS +: COUNT_BITS] = COUNT_BITS'($urandom());

    p_same = ($urandom_range(99) < 25);
    if ($urandom_range(99) < 80) begin
      p_vk = KIND_DEPENDENT;
      p_wk = KIND_DEPENDENT;
    end else begin
      p_vk = KIND_BITS'($urandom());
      p_wk = KIND_BITS'($urandom());
    end
  endtask

  initial begin
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [MODE_BITS-1:0] phase_mode [NUM_PHASES];
    int count;
    phase_mode = '{MODE_GRLEX_A, MODE_LEX, MODE_DEGREVLEX_B, MODE_UNDEF_LO, MODE_GRLEX_B,
                   MODE_DEGREVLEX_A, MODE_UNDEF_HI, MODE_LEX, MODE_DEGREVLEX_A};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle = 17;
    receiver_idle = 54;
    directed('0, '0, 1'b0, KIND_OPERATOR, KIND_OPERATOR, '0, '0, '0, '0, '0, '0, '0);
    directed('1, '1, 1'b1, KIND_SPARE, KIND_SPARE, '1, '1, '1, '1, '1, '1, '1);
    directed('0, '1, 1'b1, KIND_DEPENDENT, KIND_DEPENDENT, 0, 0, 1, 1, '0, '0, 7'h41);
    directed('1, '0, 1'b1, KIND_DEPENDENT, KIND_DEPENDENT, 0, 0, 1, 1, '0, '0, 7'h41);
    directed(32'h00000102, 32'h00000201, 1'b1, KIND_OPERATOR, KIND_OPERATOR,
             9, 4, 1, 2, '0, '0, 7'h41);
    directed(32'h01020304, 32'h04030201, 1'b1, KIND_DEPENDENT, KIND_OTHER,
             9, 4, 1, 2, '0, '0, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_OPERATOR, KIND_DEPENDENT, 3, 3, 1, 2, '0, '0, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_OTHER, 3, 3, 1, 2, '0, '0, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_SPARE, KIND_DEPENDENT, 3, 3, 1, 2, '0, '0, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_SPARE, 3, 3, 1, 2, '0, '0, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 200, 3, 1, 2, '0, '0, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 3, 200, 1, 2, '0, '0, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, NO_GROUP, 2,
             32'h01, 32'h02, 7'h41);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 1, 2,
             32'h01, 32'h02, 7'h0F);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 1, 2,
             32'h01, 32'h02, 7'h5F);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 1, 2,
             32'h01, 32'h02, 7'h7F);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 1, 1,
             32'h01010101, 32'h02020202, 7'h4F);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 1, 1,
             32'h01010101, 32'h02020202, 7'h40);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 1, 1,
             32'h00000201, 32'h00000302, 7'h21);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 3, 3,
             32'h0000AA05, 32'h0000AA05, 7'h23);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, NO_GROUP, NO_GROUP,
             32'h0000AA05, 32'h0000AA05, 7'h23);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 5, 2,
             32'h11223305, 32'h44556605, 7'h11);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 2, 5,
             32'h11223305, 32'h44556605, 7'h11);
    directed(32'h05, 32'h05, 1'b0, KIND_DEPENDENT, KIND_DEPENDENT, 7, 7, 1, 1,
             32'h80808080, 32'h7F7F7F7F, 7'h4F);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_mode(phase_mode[ph]);
      sender_idle   = (ph < 3) ? 17 : (ph < 6) ? 54 : 0;
      receiver_idle = (ph < 3) ? 54 : (ph < 6) ? 17 : 0;
      count = (phase_mode[ph] > MODE_LEX) ? UNDEF_ITEMS : PHASE_ITEMS;
      for (int n = 0; n < count; n++) begin
        if (ph == 1 && n == PHASE_ITEMS / 2) drain();
        make_random_pair();
        push_pair();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
